>>> hdl/windowed_iq_power_meter_defines.svh
// Assertion macros for the windowed I/Q power meter checker.
// Included by the checker file; depends on nothing else.
`ifndef WINDOWED_IQ_POWER_METER_DEFINES_SVH
`define WINDOWED_IQ_POWER_METER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WIPM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WIPM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/wipm_pkg.sv
// Shared types and constants for the windowed I/Q power meter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package wipm_pkg;

   localparam int SAMPLE_WIDTH_DEFAULT = 16;
   localparam int COUNT_WIDTH_DEFAULT  = 20;
   localparam int LOG_WIDTH            = 5;
   localparam int POWER_WIDTH          = 32;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [LOG_WIDTH-1:0]   LOG_RESET = LOG_WIDTH'(10);
   localparam logic [POWER_WIDTH-1:0] SUM_MAX   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic signed [15:0] sample_inphase;
      logic signed [15:0] sample_quadrature;
      logic               packet_end;
   } req_type;

   typedef struct packed {
      logic signed [15:0]      out_inphase;
      logic signed [15:0]      out_quadrature;
      logic                    out_packet_end;
      logic [POWER_WIDTH-1:0]  mean_power;
      logic [POWER_WIDTH-1:0]  window_peak;
      logic                    measurement_fresh;
      logic                    window_closed;
   } rsp_type;

   typedef struct packed {
      req_type                sample;
      logic [POWER_WIDTH-1:0] power;
      logic                   closes;
      logic [LOG_WIDTH-1:0]   window_log;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

>>> hdl/wipm_front.sv
// Front end: takes items, computes sample power, counts the window and tags closing items.
// Holds the window log register. Depends on wipm_pkg.
`default_nettype none

module wipm_front
   import wipm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire req_type              req_item,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [LOG_WIDTH-1:0] csr_data,
   input  wire queue_status_type     queue_status,
   output      logic                 push,
   output      work_type             push_entry
);

   localparam logic [LOG_WIDTH-1:0] LOG_MAX   = LOG_WIDTH'(COUNT_WIDTH - 1);
   localparam logic [LOG_WIDTH-1:0] LOG_START = (LOG_RESET > LOG_MAX) ? LOG_MAX : LOG_RESET;

   logic [LOG_WIDTH-1:0]   setting_ff, setting_in;
   logic [LOG_WIDTH-1:0]   log_ff, log_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   valid_ff, valid_in;
   work_type               entry_ff, entry_in;

   logic                          accept;
   logic [COUNT_WIDTH-1:0]        count_next;
   logic [COUNT_WIDTH-1:0]        window_len;
   logic                          closes;
   logic [LOG_WIDTH-1:0]          setting_clamped;
   logic signed [SAMPLE_WIDTH-1:0] i_s, q_s;
   logic signed [2*SAMPLE_WIDTH-1:0] i_sq, q_sq;
   logic [2*SAMPLE_WIDTH:0]       power_wide;

   assign csr_ready = 1'b1;
   assign req_stall = valid_ff && queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !queue_status.full;
   assign push_entry = entry_ff;

   always_comb begin
      i_s        = req_item.sample_inphase[SAMPLE_WIDTH-1:0];
      q_s        = req_item.sample_quadrature[SAMPLE_WIDTH-1:0];
      i_sq       = i_s * i_s;
      q_sq       = q_s * q_s;
      power_wide = {1'b0, i_sq} + {1'b0, q_sq};
      count_next = count_ff + COUNT_WIDTH'(1);
      window_len = COUNT_WIDTH'(1) << log_ff;
      closes     = (count_next == window_len);
      setting_clamped = (setting_ff > LOG_MAX) ? LOG_MAX : setting_ff;
   end

   always_comb begin
      setting_in = (csr_valid && csr_ready) ? csr_data : setting_ff;
      log_in     = log_ff;
      count_in   = count_ff;
      valid_in   = valid_ff;
      entry_in   = entry_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in            = 1'b1;
         entry_in.sample     = req_item;
         entry_in.power      = POWER_WIDTH'(power_wide);
         entry_in.closes     = closes;
         entry_in.window_log = log_ff;
         count_in            = closes ? '0 : count_next;
         if (closes) begin
            log_in = setting_clamped;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setting_ff <= LOG_RESET;
         log_ff     <= LOG_START;
         count_ff   <= '0;
         valid_ff   <= 1'b0;
      end else begin
         setting_ff <= setting_in;
         log_ff     <= log_in;
         count_ff   <= count_in;
         valid_ff   <= valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

>>> hdl/wipm_queue.sv
// Short item queue between the front end and the back end.
// Register-based ring with an occupancy count. Depends on wipm_pkg.
`default_nettype none

module wipm_queue
   import wipm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire work_type         push_entry,
   input  wire logic             pop,
   output      work_type         pop_entry,
   output      queue_status_type status
);

   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0]   PTR_LAST = PTR_WIDTH'(QUEUE_DEPTH - 1);
   localparam logic [COUNT_WIDTH-1:0] FULL_COUNT = COUNT_WIDTH'(QUEUE_DEPTH);

   work_type               entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   assign status.full  = (count_ff == FULL_COUNT);
   assign status.empty = (count_ff == '0);
   assign pop_entry    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> hdl/wipm_back.sv
// Back end: saturating power accumulation, peak tracking, window latch and result register.
// Pops tagged items from the queue. Depends on wipm_pkg.
`default_nettype none

module wipm_back
   import wipm_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire queue_status_type queue_status,
   input  wire work_type         pop_entry,
   output      logic             pop,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      rsp_type          rsp_item
);

   logic [POWER_WIDTH-1:0] sum_ff, sum_in;
   logic [POWER_WIDTH-1:0] peak_ff, peak_in;
   logic [POWER_WIDTH-1:0] held_mean_ff, held_mean_in;
   logic [POWER_WIDTH-1:0] held_peak_ff, held_peak_in;
   logic                   fresh_ff, fresh_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [POWER_WIDTH:0]   sum_wide;
   logic [POWER_WIDTH-1:0] sum_sat;
   logic [POWER_WIDTH-1:0] peak_next;

   assign pop       = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      sum_wide  = {1'b0, sum_ff} + {1'b0, pop_entry.power};
      sum_sat   = sum_wide[POWER_WIDTH] ? SUM_MAX : sum_wide[POWER_WIDTH-1:0];
      peak_next = (pop_entry.power > peak_ff) ? pop_entry.power : peak_ff;
   end

   always_comb begin
      sum_in       = sum_ff;
      peak_in      = peak_ff;
      held_mean_in = held_mean_ff;
      held_peak_in = held_peak_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (pop_entry.closes) begin
            held_mean_in = sum_sat >> pop_entry.window_log;
            held_peak_in = peak_next;
            fresh_in     = 1'b1;
            sum_in       = '0;
            peak_in      = '0;
         end else begin
            sum_in  = sum_sat;
            peak_in = peak_next;
         end
         rsp_in.out_inphase       = pop_entry.sample.sample_inphase;
         rsp_in.out_quadrature    = pop_entry.sample.sample_quadrature;
         rsp_in.out_packet_end    = pop_entry.sample.packet_end;
         rsp_in.mean_power        = held_mean_in;
         rsp_in.window_peak       = held_peak_in;
         rsp_in.measurement_fresh = fresh_in;
         rsp_in.window_closed     = pop_entry.closes;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         peak_ff      <= '0;
         held_mean_ff <= '0;
         held_peak_ff <= '0;
         fresh_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         held_mean_ff <= held_mean_in;
         held_peak_ff <= held_peak_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

>>> hdl/windowed_iq_power_meter.sv
// Windowed I/Q power meter: passes each I/Q item through and reports the mean and peak
// power of the last completed window of 2^window_log samples. The block takes one item
// per clock cycle sustained while the result side does not stall. A result is offered
// after its item has passed the front power register, loaded at the edge that accepts it,
// a queue slot and the result register, later while the result side stalls. The two-entry
// queue lets the front keep taking items while a result waits. The window log written on
// the csr port is adopted at the next window boundary and is limited to COUNT_WIDTH-1.
// Depends on wipm_pkg, wipm_front, wipm_queue and wipm_back.
`default_nettype none

module windowed_iq_power_meter
   import wipm_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire req_type              req_item,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      rsp_type              rsp_item,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [LOG_WIDTH-1:0] csr_data
);

   queue_status_type queue_status;
   logic             push;
   logic             pop;
   work_type         push_entry;
   work_type         pop_entry;

   wipm_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   wipm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (queue_status)
   );

   wipm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop_entry    (pop_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item)
   );

endmodule

`default_nettype wire

>>> hdl/wipm_checker.sv
// Port-level checker for the windowed I/Q power meter, bound to the top level.
// Depends on wipm_pkg and windowed_iq_power_meter_defines.svh.
`default_nettype none
`include "windowed_iq_power_meter_defines.svh"

module wipm_checker
   import wipm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_item
);

   logic                   seen_ff, seen_in;
   logic                   fresh_ff, fresh_in;
   logic [POWER_WIDTH-1:0] mean_ff, mean_in;
   logic [POWER_WIDTH-1:0] peak_ff, peak_in;
   logic                   rsp_accept;

   assign rsp_accept = rsp_valid && !rsp_stall;

   always_comb begin
      seen_in  = seen_ff || rsp_accept;
      fresh_in = fresh_ff || (rsp_accept && rsp_item.measurement_fresh);
      mean_in  = rsp_accept ? rsp_item.mean_power : mean_ff;
      peak_in  = rsp_accept ? rsp_item.window_peak : peak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff  <= 1'b0;
         fresh_ff <= 1'b0;
      end else begin
         seen_ff  <= seen_in;
         fresh_ff <= fresh_in;
      end
      mean_ff <= mean_in;
      peak_ff <= peak_in;
   end

   `WIPM_ASSERT_NOW(closed_sets_fresh, rsp_valid && rsp_item.window_closed, rsp_item.measurement_fresh, "window closed without fresh flag")
   `WIPM_ASSERT_NOW(fresh_is_sticky, rsp_valid && fresh_ff, rsp_item.measurement_fresh, "fresh flag dropped")
   `WIPM_ASSERT_NOW(held_values_stable, rsp_valid && seen_ff && !rsp_item.window_closed, (rsp_item.mean_power == mean_ff) && (rsp_item.window_peak == peak_ff), "held mean or peak changed without window close")
   `WIPM_ASSERT_NOW(mean_below_peak, rsp_valid, rsp_item.mean_power <= rsp_item.window_peak, "mean power above window peak")
   `WIPM_ASSERT_NEXT(stalled_rsp_holds, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "stalled result changed")

endmodule

bind windowed_iq_power_meter wipm_checker u_checker (.*);

`default_nettype wire
